// ===== sv/cmmrtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmmrtt_pkg: shared types and constants of the min-RTT path selector
// Holds the transaction structs, command codes and configuration register
// indexes used by the selector and its path evaluation unit.
// ----------------------------------------------------------------------------
package cmmrtt_pkg;

  // Command codes of an input transaction.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_MASK_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_MASK_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_MASK_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_MASK_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PTO_THRESH  = 3'd4;

  // Number of class mask registers; paths beyond them have an empty mask.
  localparam int NUM_MASK_REGS = 4;

  // Reset value of the probe-timeout skip threshold.
  localparam logic [3:0] PTO_THRESH_RESET = 4'd3;

  // Width used to compare path numbers of any supported path count.
  localparam int CMP_W = 4;

  // Input transaction.
  typedef struct packed {
    logic        cmd;
    logic [1:0]  path_index;
    logic        path_active;
    logic        path_frozen;
    logic        socket_error;
    logic [3:0]  pto_count;
    logic        send_ok;
    logic        cwnd_open;
    logic [31:0] srtt;
    logic [5:0]  dscp;
    logic        need_cwnd;
    logic        reinject;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic       found;
    logic [1:0] chosen_path;
    logic       used_fallback;
    logic       cwnd_blocked;
  } out_item_t;

  // Status flags of one path table entry.
  typedef struct packed {
    logic       active;
    logic       frozen;
    logic       sock_err;
    logic [3:0] pto;
    logic       send_ok;
    logic       cwnd_open;
  } path_flags_t;

  // Per-item qualifiers handed to the evaluation unit.
  typedef struct packed {
    logic       need_cwnd;
    logic       excluded;
    logic       mask_ok;
    logic       have;
    logic [3:0] pto_thresh;
  } eval_ctl_t;

  // Verdict of the evaluation unit on one path.
  typedef struct packed {
    logic usable;
    logic sendable;
    logic take;
  } eval_res_t;

endpackage

// ===== sv/class_masked_min_rtt_path_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_masked_min_rtt_path_select: class-masked minimum-RTT path selector
// Keeps a status table of NUM_PATHS paths and picks the usable, sendable
// path with the lowest smoothed RTT for each select transaction.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters on in_data when start is high and busy is low.
//   An update (cmd = update) rewrites one table entry and returns an all-zero
//   result in the cycle after acceptance; busy stays low, so updates can be
//   issued every cycle.
//   A select scans the table with one shared evaluation unit, one path per
//   cycle. An untagged packet, or a tagged one whose class-restricted pass
//   finds a path, needs one pass over the table; a tagged packet that falls
//   back to the unrestricted pass needs two. busy is high during the scan,
//   and the result appears on the cycle after the last scan step.
//   Each result sits on out_data for exactly one cycle, marked by out_valid;
//   the receiver cannot stall it.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//   Reset marks every path inactive, clears the class masks and sets the
//   probe-timeout threshold to 3.
// ----------------------------------------------------------------------------
module class_masked_min_rtt_path_select #(
  parameter int NUM_PATHS = 4,
  parameter int RTT_BITS  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  cmmrtt_pkg::in_item_t                   in_data,
  output logic                                   out_valid,
  output cmmrtt_pkg::out_item_t                  out_data,
  input  logic                                   cfg_we,
  input  logic [cmmrtt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cmmrtt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cmmrtt_pkg::*;

  localparam int IDX_W = $clog2(NUM_PATHS);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] path_mask_r [NUM_MASK_REGS];
  logic [3:0]            pto_thresh_r;

  // Path status table.
  path_flags_t           flags_r [NUM_PATHS];
  logic [RTT_BITS-1:0]   srtt_r  [NUM_PATHS];

  // Sequencer and per-pass state.
  state_t                state_r;
  logic [IDX_W-1:0]      pidx_r;
  logic                  have_r;
  logic [RTT_BITS-1:0]   best_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic                  usable_seen_r;
  logic                  any_send_r;
  logic                  fb_r;
  logic [5:0]            dscp_r;
  logic                  need_cwnd_r;
  logic                  reinject_r;
  logic [1:0]            excl_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic                  accept;
  logic                  last_path;
  logic [CFG_DATA_W-1:0] cur_mask;
  eval_ctl_t             ev_ctl;
  eval_res_t             ev_res;
  logic                  have_nxt;
  logic [RTT_BITS-1:0]   best_nxt;
  logic [IDX_W-1:0]      best_idx_nxt;
  logic                  usable_seen_nxt;
  logic                  any_send_nxt;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign last_path = (pidx_r == IDX_W'(NUM_PATHS - 1));

  // Configuration register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MASK_REGS; i++) begin
        path_mask_r[i] <= '0;
      end
      pto_thresh_r <= PTO_THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATH_MASK_0: path_mask_r[0] <= cfg_data;
        CFG_PATH_MASK_1: path_mask_r[1] <= cfg_data;
        CFG_PATH_MASK_2: path_mask_r[2] <= cfg_data;
        CFG_PATH_MASK_3: path_mask_r[3] <= cfg_data;
        CFG_PTO_THRESH:  pto_thresh_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Table writes from update transactions. Reset only needs to clear the
  // active flags: an inactive path is never looked at further.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PATHS; i++) begin
        flags_r[i].active <= 1'b0;
      end
    end else if (accept && (in_data.cmd == CMD_UPDATE)) begin
      for (int i = 0; i < NUM_PATHS; i++) begin
        if (CMP_W'(in_data.path_index) == CMP_W'(i)) begin
          flags_r[i].active    <= in_data.path_active;
          flags_r[i].frozen    <= in_data.path_frozen;
          flags_r[i].sock_err  <= in_data.socket_error;
          flags_r[i].pto       <= in_data.pto_count;
          flags_r[i].send_ok   <= in_data.send_ok;
          flags_r[i].cwnd_open <= in_data.cwnd_open;
          srtt_r[i]            <= RTT_BITS'(in_data.srtt);
        end
      end
    end
  end

  // Class mask of the path under scan; paths past the mask registers have none.
  always_comb begin
    cur_mask = '0;
    for (int i = 0; i < NUM_MASK_REGS; i++) begin
      if (CMP_W'(pidx_r) == CMP_W'(i)) begin
        cur_mask = path_mask_r[i];
      end
    end
  end

  // Qualifiers for the path under scan. The class restriction applies only
  // to the first pass of a tagged packet.
  always_comb begin
    ev_ctl.need_cwnd  = need_cwnd_r;
    ev_ctl.excluded   = reinject_r && (CMP_W'(pidx_r) == CMP_W'(excl_r));
    ev_ctl.mask_ok    = (dscp_r == 6'd0) || fb_r || cur_mask[dscp_r];
    ev_ctl.have       = have_r;
    ev_ctl.pto_thresh = pto_thresh_r;
  end

  cmmrtt_eval #(
    .RTT_BITS (RTT_BITS)
  ) u_eval (
    .flags (flags_r[pidx_r]),
    .srtt  (srtt_r[pidx_r]),
    .best  (best_r),
    .ctl   (ev_ctl),
    .res   (ev_res)
  );

  // Running best of the current pass after this step.
  always_comb begin
    have_nxt        = have_r || ev_res.take;
    best_nxt        = ev_res.take ? srtt_r[pidx_r] : best_r;
    best_idx_nxt    = ev_res.take ? pidx_r : best_idx_r;
    usable_seen_nxt = usable_seen_r || ev_res.usable;
    any_send_nxt    = any_send_r || ev_res.sendable;
  end

  // Sequencer: accepts transactions, steps the scan, issues results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      out_data_r    <= '0;
      pidx_r        <= '0;
      have_r        <= 1'b0;
      best_r        <= '0;
      best_idx_r    <= '0;
      usable_seen_r <= 1'b0;
      any_send_r    <= 1'b0;
      fb_r          <= 1'b0;
      dscp_r        <= '0;
      need_cwnd_r   <= 1'b0;
      reinject_r    <= 1'b0;
      excl_r        <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.cmd == CMD_UPDATE) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '0;
            end else begin
              dscp_r        <= in_data.dscp;
              need_cwnd_r   <= in_data.need_cwnd;
              reinject_r    <= in_data.reinject;
              excl_r        <= in_data.path_index;
              pidx_r        <= '0;
              have_r        <= 1'b0;
              best_idx_r    <= '0;
              usable_seen_r <= 1'b0;
              any_send_r    <= 1'b0;
              fb_r          <= 1'b0;
              state_r       <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!last_path) begin
            pidx_r        <= pidx_r + 1'b1;
            have_r        <= have_nxt;
            best_r        <= best_nxt;
            best_idx_r    <= best_idx_nxt;
            usable_seen_r <= usable_seen_nxt;
            any_send_r    <= any_send_nxt;
          end else if (!have_nxt && (dscp_r != 6'd0) && !fb_r) begin
            // Restricted pass came up empty: rescan over all paths.
            fb_r          <= 1'b1;
            pidx_r        <= '0;
            have_r        <= 1'b0;
            best_idx_r    <= '0;
            usable_seen_r <= 1'b0;
            any_send_r    <= 1'b0;
          end else begin
            out_valid_r              <= 1'b1;
            out_data_r.found         <= have_nxt;
            out_data_r.chosen_path   <= have_nxt ? 2'(best_idx_nxt) : 2'd0;
            out_data_r.used_fallback <= fb_r;
            out_data_r.cwnd_blocked  <= usable_seen_nxt && !any_send_nxt;
            state_r                  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // The end of a scan always delivers its result in the same edge.
  a_scan_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("select scan ended without a result strobe");

  // An accepted update answers on the very next cycle.
  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.cmd == CMD_UPDATE) |=> out_valid && !out_data.found)
    else $error("update transaction did not return an empty result");

  // A found path implies a sendable candidate, so it cannot be blocked.
  a_found_not_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> !out_data.cwnd_blocked)
    else $error("result reports both a chosen path and congestion block");

  // No path found reports path zero.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> (out_data.chosen_path == 2'd0))
    else $error("chosen_path nonzero without a found path");

  // The fallback pass only ever runs for tagged packets.
  a_fallback_tagged: assert property (@(posedge clk) disable iff (!rst_n)
    fb_r |-> (dscp_r != 6'd0))
    else $error("fallback pass entered for an untagged packet");

endmodule

// ===== sv/cmmrtt_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmmrtt_eval: shared path evaluation unit
// Judges one path entry per cycle: usable, sendable, and whether its RTT
// beats the best candidate seen so far in the current pass.
// ----------------------------------------------------------------------------
module cmmrtt_eval #(
  parameter int RTT_BITS = 32
) (
  input  cmmrtt_pkg::path_flags_t flags,
  input  logic [RTT_BITS-1:0]     srtt,
  input  logic [RTT_BITS-1:0]     best,
  input  cmmrtt_pkg::eval_ctl_t   ctl,
  output cmmrtt_pkg::eval_res_t   res
);
  import cmmrtt_pkg::*;

  logic healthy;
  logic faster;

  // Health checks of the entry itself, then the per-item exclusions.
  assign healthy = flags.active && !flags.frozen && !flags.sock_err &&
                   (flags.pto < ctl.pto_thresh);

  // The one magnitude comparator, shared by every path of every pass.
  assign faster = srtt < best;

  always_comb begin
    res.usable   = healthy && !ctl.excluded && ctl.mask_ok;
    res.sendable = res.usable && flags.send_ok && (!ctl.need_cwnd || flags.cwnd_open);
    res.take     = res.sendable && (!ctl.have || faster);
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the class-masked min-RTT path selector
// Drives update and select transactions through the start/busy port and
// programs the class masks and the probe-timeout threshold between phases.
// A built-in model of the path table predicts every result, unless the directed
// table types one in; the expectation is compared field by field with what the
// selector returns. A short directed table comes first, followed by random
// phases under several register settings, with random gaps on the input side.
// ----------------------------------------------------------------------------
module tb;
  import cmmrtt_pkg::*;

  localparam int NUM_PATHS  = 4;
  localparam int RTT_BITS   = 32;
  localparam int CLK_HALF   = 2;
  localparam int RST_CYCLES = 12;
  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_REPORT = 10;
  localparam int TAIL_WAIT  = 3 * (2 * NUM_PATHS + 1);

  // One entry of the path status table as the model keeps it.
  typedef struct packed {
    logic                active;
    logic                frozen;
    logic                sock_err;
    logic [3:0]          pto;
    logic                send_ok;
    logic                cwnd_open;
    logic [RTT_BITS-1:0] srtt;
  } path_entry_t;

  // Outcome of one min-RTT scan over the table.
  typedef struct packed {
    logic       have;
    logic [1:0] idx;
    logic       blocked;
  } scan_t;

  // Directed stimulus: either a transaction or a register write.
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    in_item_t                 item;
    logic                     typed;
    out_item_t                want;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    val;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Expected result typed into the directed table for the transaction on in_data.
  logic                  exp_typed;
  out_item_t             exp_typed_val;

  // Set while start has been driven high and not yet dropped.
  logic                  start_hi;

  // Model state and configuration.
  path_entry_t           path_tbl [NUM_PATHS];
  logic [63:0]           class_mask [NUM_MASK_REGS];
  logic [3:0]            pto_limit;

  out_item_t             choice_q [$];
  dir_row_t              dir_tbl [$];
  int                    n_sent;
  int                    n_done;
  int                    n_err;
  int                    idle_cnt;

  class_masked_min_rtt_path_select #(
    .NUM_PATHS(NUM_PATHS),
    .RTT_BITS (RTT_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model of the selector
  // ---------------------------------------------------------------------------

  // One pass over all paths; a nonzero class bit restricts the candidates.
  function automatic scan_t min_rtt_scan(input logic [63:0] need, input in_item_t it);
    scan_t               s;
    path_entry_t         e;
    logic [63:0]         m;
    logic                usable_seen;
    logic                any_send;
    logic [RTT_BITS-1:0] best;
    s           = '0;
    usable_seen = 1'b0;
    any_send    = 1'b0;
    best        = '0;
    for (int p = 0; p < NUM_PATHS; p++) begin
      e = path_tbl[p];
      m = (p < NUM_MASK_REGS) ? class_mask[p] : 64'd0;
      if (!e.active || e.frozen || e.sock_err || e.pto >= pto_limit) continue;
      if (it.reinject && p == int'(it.path_index)) continue;
      if (need != 64'd0 && (m & need) == 64'd0) continue;
      usable_seen = 1'b1;
      if (!e.send_ok || (it.need_cwnd && !e.cwnd_open)) continue;
      any_send = 1'b1;
      // Strictly lower RTT wins, so ties stay with the lower index.
      if (!s.have || e.srtt < best) begin
        s.have = 1'b1;
        s.idx  = p[1:0];
        best   = e.srtt;
      end
    end
    s.blocked = usable_seen && !any_send;
    return s;
  endfunction

  // Applies one transaction to the model and returns the result it should give.
  function automatic out_item_t next_path_choice(input in_item_t it);
    out_item_t r;
    scan_t     s;
    r = '0;
    if (it.cmd == CMD_UPDATE) begin
      if (int'(it.path_index) < NUM_PATHS) begin
        path_tbl[it.path_index] = '{active: it.path_active, frozen: it.path_frozen,
                                    sock_err: it.socket_error, pto: it.pto_count,
                                    send_ok: it.send_ok, cwnd_open: it.cwnd_open,
                                    srtt: it.srtt[RTT_BITS-1:0]};
      end
      return r;
    end
    s = min_rtt_scan((it.dscp != 6'd0) ? (64'd1 << it.dscp) : 64'd0, it);
    // A tagged packet with no path in its class retries over all paths.
    if (!s.have && it.dscp != 6'd0) begin
      r.used_fallback = 1'b1;
      s = min_rtt_scan(64'd0, it);
    end
    r.found        = s.have;
    r.chosen_path  = s.have ? s.idx : 2'd0;
    r.cwnd_blocked = s.blocked;
    return r;
  endfunction

  function automatic string fmt_result(input out_item_t r);
    return $sformatf("found=%0d path=%0d fallback=%0d blocked=%0d",
                     r.found, r.chosen_path, r.used_fallback, r.cwnd_blocked);
  endfunction

  task automatic note_error(input string msg);
    n_err++;
    if (n_err <= MAX_REPORT) $display("tb: error: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: tracks accepted transactions, register writes and results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    logic      moved;
    if (!rst_n) begin
      foreach (path_tbl[i]) path_tbl[i] = '0;
      foreach (class_mask[i]) class_mask[i] = '0;
      pto_limit = PTO_THRESH_RESET;
      idle_cnt  = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we) begin
        if (int'(cfg_index) < NUM_MASK_REGS) class_mask[cfg_index] = cfg_data;
        else if (cfg_index == CFG_PTO_THRESH) pto_limit = cfg_data[3:0];
      end
      // Accepted transaction: update the model and queue its result.
      if (start && busy === 1'b0) begin
        want = next_path_choice(in_data);
        if (exp_typed) want = exp_typed_val;
        choice_q.push_back(want);
        moved = 1'b1;
      end
      // Returned result: compare with the oldest expectation.
      if (out_valid === 1'b1) begin
        moved = 1'b1;
        n_done++;
        got = out_data;
        if (choice_q.size() == 0) begin
          note_error($sformatf("result with nothing expected: %s", fmt_result(got)));
        end else begin
          want = choice_q.pop_front();
          if (got.found !== want.found || got.chosen_path !== want.chosen_path ||
              got.used_fallback !== want.used_fallback ||
              got.cwnd_blocked !== want.cwnd_blocked) begin
            note_error($sformatf("mismatch: expected %s, got %s",
                                 fmt_result(want), fmt_result(got)));
          end
        end
      end
      // Watchdog on stretches with no transaction in either direction.
      if (moved) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t upd(input logic [1:0] path, input logic act, input logic frz,
                                   input logic err, input logic [3:0] pto, input logic sok,
                                   input logic cwo, input logic [31:0] rtt);
    in_item_t it;
    it              = '0;
    it.cmd          = CMD_UPDATE;
    it.path_index   = path;
    it.path_active  = act;
    it.path_frozen  = frz;
    it.socket_error = err;
    it.pto_count    = pto;
    it.send_ok      = sok;
    it.cwnd_open    = cwo;
    it.srtt         = rtt;
    return it;
  endfunction

  function automatic in_item_t sel(input logic [1:0] path, input logic [5:0] dscp,
                                   input logic chk, input logic rei);
    in_item_t it;
    it            = '0;
    it.cmd        = CMD_SELECT;
    it.path_index = path;
    it.dscp       = dscp;
    it.need_cwnd  = chk;
    it.reinject   = rei;
    return it;
  endfunction

  function automatic out_item_t res(input logic fnd, input logic [1:0] path,
                                    input logic fb, input logic blk);
    out_item_t r;
    r.found         = fnd;
    r.chosen_path   = path;
    r.used_fallback = fb;
    r.cwnd_blocked  = blk;
    return r;
  endfunction

  task automatic add_item(input in_item_t it, input logic typed, input out_item_t want);
    dir_row_t r;
    r.kind  = ROW_ITEM;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    r.idx   = '0;
    r.val   = '0;
    dir_tbl.push_back(r);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r.kind  = ROW_CFG;
    r.item  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    r.idx   = idx;
    r.val   = val;
    dir_tbl.push_back(r);
  endtask

  function automatic logic [63:0] rand_mask();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return {$urandom(), $urandom()};
      default: return {$urandom(), $urandom()} & {$urandom(), $urandom()};
    endcase
  endfunction

  // Small RTTs make ties between paths common.
  function automatic logic [31:0] rand_rtt();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  // Random transaction; fields that the command ignores stay fully random.
  function automatic in_item_t rand_item();
    logic [63:0] raw;
    in_item_t    it;
    raw = {$urandom(), $urandom()};
    it  = raw[$bits(in_item_t)-1:0];
    if ($urandom_range(0, 99) < 40) begin
      it.cmd          = CMD_UPDATE;
      it.path_active  = ($urandom_range(0, 99) < 80);
      it.path_frozen  = ($urandom_range(0, 99) < 12);
      it.socket_error = ($urandom_range(0, 99) < 12);
      it.pto_count    = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 2))
                                                     : 4'($urandom_range(0, 15));
      it.send_ok      = ($urandom_range(0, 99) < 85);
      it.cwnd_open    = ($urandom_range(0, 99) < 70);
      it.srtt         = rand_rtt();
    end else begin
      it.cmd       = CMD_SELECT;
      it.dscp      = ($urandom_range(0, 99) < 25) ? 6'd0 : 6'($urandom_range(1, 63));
      it.need_cwnd = ($urandom_range(0, 1) == 1);
      it.reinject  = ($urandom_range(0, 99) < 30);
    end
    return it;
  endfunction

  // Drops start once, if it is still driven high.
  task automatic drop_start();
    if (start_hi) begin
      start    <= 1'b0;
      start_hi = 1'b0;
    end
  endtask

  // Presents one transaction and waits until the selector takes it.
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    start         <= 1'b1;
    start_hi      = 1'b1;
    in_data       <= it;
    exp_typed     <= typed;
    exp_typed_val <= want;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    n_sent++;
  endtask

  // Random pause on the input side: mostly none or short, now and then long.
  task automatic idle_gap(input logic quiet);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 50) n = 0;
    else if (pick < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      drop_start();
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops issuing and waits until every queued result has come back.
  task automatic wait_idle();
    drop_start();
    while (n_done < n_sent) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input logic last);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (last) cfg_we <= 1'b0;
  endtask

  // Programs every register, plus one write to an unused index.
  task automatic program_regs(input logic [63:0] m0, input logic [63:0] m1,
                              input logic [63:0] m2, input logic [63:0] m3,
                              input logic [3:0] thr);
    logic [CFG_IDX_W-1:0] spare;
    spare = CFG_IDX_W'(int'(CFG_PTO_THRESH) + 1 + int'($urandom_range(0, 2)));
    wait_idle();
    cfg_write(CFG_PATH_MASK_0, m0, 1'b0);
    cfg_write(CFG_PATH_MASK_1, m1, 1'b0);
    cfg_write(CFG_PATH_MASK_2, m2, 1'b0);
    cfg_write(CFG_PATH_MASK_3, m3, 1'b0);
    cfg_write(spare, {$urandom(), $urandom()}, 1'b0);
    cfg_write(CFG_PTO_THRESH, {60'd0, thr}, 1'b1);
  endtask

  task automatic build_directed();
    // Fresh table: every path inactive, so nothing is found.
    add_item(sel(2'd0, 6'd0, 1'b0, 1'b0), 1'b1, res(1'b0, 2'd0, 1'b0, 1'b0));
    add_item(sel(2'd0, 6'd63, 1'b0, 1'b0), 1'b1, res(1'b0, 2'd0, 1'b1, 1'b0));
    // Updates always return an all-zero result.
    add_item(upd(2'd0, 1'b1, 1'b0, 1'b0, 4'd0, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b1, '0);
    add_item(upd(2'd1, 1'b1, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 32'd0), 1'b1, '0);
    add_item(upd(2'd2, 1'b1, 1'b1, 1'b0, 4'd0, 1'b1, 1'b1, 32'd1), 1'b1, '0);
    add_item(upd(2'd3, 1'b1, 1'b0, 1'b1, 4'd15, 1'b1, 1'b1, 32'd5), 1'b1, '0);
    // Window check on and off; reinjection leaving only a blocked path.
    add_item(sel(2'd0, 6'd0, 1'b0, 1'b0), 1'b0, '0);
    add_item(sel(2'd0, 6'd0, 1'b1, 1'b0), 1'b0, '0);
    add_item(sel(2'd0, 6'd0, 1'b1, 1'b1), 1'b0, '0);
    // Class masks at their extremes and the highest threshold.
    add_cfg(CFG_PATH_MASK_0, 64'h8000_0000_0000_0000);
    add_cfg(CFG_PATH_MASK_1, 64'h0000_0000_0000_0002);
    add_cfg(CFG_PATH_MASK_2, '1);
    add_cfg(CFG_PATH_MASK_3, '0);
    add_cfg(CFG_PTO_THRESH, 64'd15);
    // Class hit, class blocked with fallback, class with only a frozen path.
    add_item(sel(2'd3, 6'd63, 1'b0, 1'b0), 1'b0, '0);
    add_item(sel(2'd3, 6'd1, 1'b1, 1'b0), 1'b0, '0);
    add_item(sel(2'd3, 6'd5, 1'b0, 1'b0), 1'b0, '0);
    add_item(upd(2'd3, 1'b1, 1'b0, 1'b0, 4'd14, 1'b1, 1'b1, 32'd5), 1'b1, '0);
    add_item(sel(2'd0, 6'd0, 1'b0, 1'b0), 1'b0, '0);
    // A zero threshold skips every path.
    add_cfg(CFG_PTO_THRESH, 64'd0);
    add_item(sel(2'd0, 6'd0, 1'b0, 1'b0), 1'b1, res(1'b0, 2'd0, 1'b0, 1'b0));
    add_item(sel(2'd0, 6'd63, 1'b0, 1'b0), 1'b1, res(1'b0, 2'd0, 1'b1, 1'b0));
    // A write past the last register changes nothing; lowest threshold.
    add_cfg(CFG_IDX_W'(int'(CFG_PTO_THRESH) + 1), '1);
    add_cfg(CFG_PTO_THRESH, 64'd1);
    // Equal RTTs go to the lower index unless that one is excluded.
    add_item(upd(2'd2, 1'b1, 1'b0, 1'b0, 4'd0, 1'b1, 1'b1, 32'd0), 1'b1, '0);
    add_item(sel(2'd1, 6'd0, 1'b0, 1'b1), 1'b0, '0);
    add_item(sel(2'd0, 6'd0, 1'b0, 1'b0), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic        last_cfg;
    logic        quiet;
    logic [3:0]  thr;
    logic [63:0] m [4];
    int          n_items;
    start         <= 1'b0;
    in_data       <= '0;
    exp_typed     <= 1'b0;
    exp_typed_val <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    start_hi = 1'b0;
    n_sent   = 0;
    n_done   = 0;
    n_err    = 0;
    idle_cnt = 0;
    build_directed();
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; consecutive register writes share one write burst.
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        if (!cfg_we) wait_idle();
        last_cfg = (i + 1 == dir_tbl.size()) || (dir_tbl[i + 1].kind != ROW_CFG);
        cfg_write(dir_tbl[i].idx, dir_tbl[i].val, last_cfg);
      end else begin
        send_item(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].want);
        idle_gap(1'b0);
      end
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      foreach (m[i]) m[i] = rand_mask();
      quiet   = 1'b0;
      n_items = 200;
      case (ph)
        0: begin
          foreach (m[i]) m[i] = '1;
          thr = 4'd15;
        end
        1: begin
          foreach (m[i]) m[i] = '0;
          thr = 4'd1;
        end
        2: begin
          thr   = PTO_THRESH_RESET;
          quiet = 1'b1;
        end
        3: begin
          thr     = 4'd0;
          n_items = 60;
        end
        4:       thr = 4'($urandom_range(1, 15));
        default: thr = 4'($urandom_range(0, 15));
      endcase
      program_regs(m[0], m[1], m[2], m[3], thr);
      for (int k = 0; k < n_items; k++) begin
        send_item(rand_item(), 1'b0, '0);
        idle_gap(quiet);
      end
    end

    wait_idle();
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_err == 0 && choice_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cmmrtt_pkg.sv
sv/cmmrtt_eval.sv
sv/class_masked_min_rtt_path_select.sv
bench/tb.sv
